/* sv/act_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ACES filmic tonemap package
// Shared constants and types for the tonemap pipeline.
// ----------------------------------------------------------------------------
package act_pkg;

    localparam int IN_FRAC_BITS  = 12;
    localparam int OUT_FRAC_BITS = 16;
    localparam int IN_W          = 24;
    localparam int OUT_W         = OUT_FRAC_BITS + 1;
    localparam int Q_W           = OUT_FRAC_BITS + 1;
    localparam int X_W           = IN_FRAC_BITS + 6;
    localparam int T_W           = 38;
    localparam int P_W           = 54;
    localparam int D_W           = P_W - 2;
    localparam int NUM_CELLS     = Q_W;

    localparam logic signed [X_W-1:0] X_MIN = X_W'(-(1 <<< IN_FRAC_BITS));
    localparam logic signed [X_W-1:0] X_MAX = X_W'(16 <<< IN_FRAC_BITS);

    localparam logic signed [T_W-1:0] K_A  = T_W'(164495);
    localparam logic signed [T_W-1:0] K_BS = T_W'(64'sd1966 <<< IN_FRAC_BITS);
    localparam logic signed [T_W-1:0] K_C  = T_W'(159252);
    localparam logic signed [T_W-1:0] K_DS = T_W'(64'sd38666 <<< IN_FRAC_BITS);
    localparam logic signed [P_W-1:0] K_ES = P_W'(64'sd9175 <<< (2 * IN_FRAC_BITS));

    localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1 << OUT_FRAC_BITS);

    typedef struct packed {
        logic [D_W-1:0] rem;
        logic [D_W-1:0] den;
        logic [Q_W-1:0] quo;
        logic           sat;
        logic           zero;
    } ch_t;

    typedef struct packed {
        logic           valid;
        ch_t [2:0]      ch;
    } cell_t;

endpackage
`default_nettype wire

/* sv/aces_filmic_tonemap.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ACES filmic tonemap
// The pipeline has four front-end stages, one divider cell per quotient
// bit (17), and the output register.
// Throughput is one pixel per cycle; the whole pipeline holds while the
// result is not taken. Reset clears only the valid bits of the stages.
// ----------------------------------------------------------------------------
module aces_filmic_tonemap
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,  // in_red[23:0], in_green[47:24], in_blue[71:48]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata   // out_red[16:0], out_green[33:17], out_blue[50:34]
);
    import act_pkg::*;

    logic                  en;
    logic [3:0]            fv_reg;
    ch_t [2:0]             front_ch;
    cell_t                 chain [NUM_CELLS+1];
    logic [3*OUT_W-1:0]    out_reg, out_next;
    logic                  ov_reg;

    assign en            = !ov_reg || m_axis_tready;
    assign s_axis_tready = en;

    for (genvar c = 0; c < 3; c++)
    begin : g_front
        act_front u_front
        (
            .clk    (clk),
            .en     (en),
            .x_in   (s_axis_tdata[c*IN_W +: IN_W]),
            .ch_out (front_ch[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (en)
            fv_reg <= {fv_reg[2:0], s_axis_tvalid};
    end

    assign chain[0].valid = fv_reg[3];
    assign chain[0].ch    = front_ch;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        act_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (chain[k]),
            .cell_out (chain[k+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (chain[NUM_CELLS].ch[i].sat)
                out_next[i*OUT_W +: OUT_W] = OUT_ONE;
            else if (chain[NUM_CELLS].ch[i].zero)
                out_next[i*OUT_W +: OUT_W] = '0;
            else
                out_next[i*OUT_W +: OUT_W] =
                    OUT_W'(({1'b0, chain[NUM_CELLS].ch[i].quo} + (Q_W+1)'(1)) >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= chain[NUM_CELLS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {(56 - 3*OUT_W)'(0), out_reg};

endmodule
`default_nettype wire

/* sv/act_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ACES tonemap front end
// Clamps one channel and forms the numerator and denominator over three
// registered stages, then classifies the ratio in a fourth.
// ----------------------------------------------------------------------------
module act_front
(
    input  wire                            clk,
    input  wire                            en,
    input  wire logic signed [act_pkg::IN_W-1:0] x_in,
    output act_pkg::ch_t                   ch_out
);
    import act_pkg::*;

    logic signed [X_W-1:0] x1_reg, x1_next, x2_reg;
    logic signed [T_W-1:0] ta_reg, ta_next, tc_reg, tc_next;
    logic signed [P_W-1:0] num_reg, num_next, den_reg, den_next;
    ch_t                   ch_reg, ch_next;

    always_comb
    begin
        if (x_in < IN_W'(X_MIN))
            x1_next = X_MIN;
        else if (x_in > IN_W'(X_MAX))
            x1_next = X_MAX;
        else
            x1_next = X_W'(x_in);
        ta_next  = T_W'(x1_reg) * K_A + K_BS;
        tc_next  = T_W'(x1_reg) * K_C + K_DS;
        num_next = P_W'(x2_reg) * P_W'(ta_reg);
        den_next = P_W'(x2_reg) * P_W'(tc_reg) + K_ES;
        ch_next.rem  = num_reg[D_W-1:0];
        ch_next.den  = den_reg[D_W-1:0];
        ch_next.quo  = '0;
        ch_next.zero = (num_reg <= 0);
        ch_next.sat  = (num_reg >= den_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x1_next;
            x2_reg  <= x1_reg;
            ta_reg  <= ta_next;
            tc_reg  <= tc_next;
            num_reg <= num_next;
            den_reg <= den_next;
            ch_reg  <= ch_next;
        end
    end

    assign ch_out = ch_reg;

endmodule
`default_nettype wire

/* sv/act_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ACES tonemap divider cell
// Produces one restoring-division quotient bit for each of the three channels
// and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module act_div_cell
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           en,
    input  act_pkg::cell_t cell_in,
    output act_pkg::cell_t cell_out
);
    import act_pkg::*;

    cell_t          cell_next;
    logic           valid_reg;
    ch_t [2:0]      ch_reg;
    logic [D_W:0]   r2 [3];
    logic [2:0]     ge;

    always_comb
    begin
        cell_next = cell_in;
        for (int i = 0; i < 3; i++)
        begin
            r2[i] = {cell_in.ch[i].rem, 1'b0};
            ge[i] = (r2[i] >= {1'b0, cell_in.ch[i].den});
            cell_next.ch[i].rem = ge[i] ? D_W'(r2[i] - {1'b0, cell_in.ch[i].den})
                                        : D_W'(r2[i]);
            cell_next.ch[i].quo = {cell_in.ch[i].quo[Q_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= cell_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ch_reg <= cell_next.ch;
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.ch    = ch_reg;

endmodule
`default_nettype wire
